@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms of bsrs_dp. Each is sampled on clk and is off
// while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHK_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define CHK_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

`endif

@@ hw/rtl/bsrs_pkg.sv @@
// ----------------------------------------------------------------------------
// bsrs_pkg
// Types, codes and defaults shared by the batched selective repeat sender.
// ----------------------------------------------------------------------------
package bsrs_pkg;

	localparam int MAX_WINDOW_DEF   = 64;
	localparam int FULL_PAYLOAD_DEF = 1456;

	localparam int CNT_W = 7;

	localparam logic [1:0] CMD_BEGIN = 2'd0;
	localparam logic [1:0] CMD_RX    = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	localparam logic [1:0] RX_ACK = 2'd3;

	localparam logic [1:0] EV_SEND    = 2'd0;
	localparam logic [1:0] EV_DONE    = 2'd1;
	localparam logic [1:0] EV_REFUSED = 2'd2;

	localparam logic [1:0] PKT_START = 2'd0;
	localparam logic [1:0] PKT_END   = 2'd1;
	localparam logic [1:0] PKT_DATA  = 2'd2;

	localparam logic CFG_WINDOW  = 1'b0;
	localparam logic CFG_TIMEOUT = 1'b1;

	localparam logic [CNT_W-1:0] WINDOW_RST  = 7'd8;
	localparam logic [15:0]      TIMEOUT_RST = 16'd500;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] packet_count;
		logic [10:0] last_length;
		logic [30:0] start_seq;
		logic [1:0]  rx_type;
		logic [31:0] rx_seq;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  event_res;
		logic [1:0]  pkt_type;
		logic [31:0] pkt_seq;
		logic [10:0] pkt_length;
		logic        last;
	} out_item_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_WSTART,
		PH_DATA,
		PH_WEND
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LAUNCH,
		ST_SCAN
	} ctl_state_t;

	typedef struct packed {
		logic latch;
		logic exec;
		logic launch;
		logic scan;
	} ctl_cmd_t;

	typedef struct packed {
		logic slot_free;
		logic exec_launch;
		logic exec_scan;
		logic launch_scan;
		logic scan_done;
	} dp_sts_t;

endpackage

@@ hw/rtl/batched_selective_repeat_sender.sv @@
// ----------------------------------------------------------------------------
// batched_selective_repeat_sender
// Sender side of a batched selective repeat transfer.
//
// The in channel carries one command per beat: begin a transfer, report a
// received packet, or one timer tick. The out channel carries the resulting
// events, one per beat, with last set on the final beat caused by a command.
// Commands that cause nothing produce no beat. The cfg port writes the window
// size and the timeout; the user must write them only while the block is
// idle, since the block itself does not enforce it. A command is taken only
// when the previous one has been fully processed. A start, refused or complete
// event is composed in the exec state and loaded into the output register once
// the slot is free; an end packet is loaded from the launch state. A batch
// launch passes the exec and launch states before the first data beat, then
// sends one data beat per cycle while the slot is free; a resend walks the
// pending bitmap one position per cycle while the slot is free. The single
// output register lets a new command enter while a beat still waits.
// When the receiver stalls, the sequencer holds and no beat is lost.
// Reset clears the transfer state, returns the registers to a window of 8 and
// a timeout of 500 ticks, and leaves the block idle with no beat pending.
// ----------------------------------------------------------------------------
module batched_selective_repeat_sender #(
	parameter int MAX_WINDOW   = bsrs_pkg::MAX_WINDOW_DEF,
	parameter int FULL_PAYLOAD = bsrs_pkg::FULL_PAYLOAD_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  bsrs_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output bsrs_pkg::out_item_t out_data
);
	import bsrs_pkg::*;

	ctl_cmd_t ctl_cmd;
	dp_sts_t  dp_sts;

	bsrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (dp_sts),
		.cmd      (ctl_cmd)
	);

	bsrs_dp #(
		.MAX_WINDOW   (MAX_WINDOW),
		.FULL_PAYLOAD (FULL_PAYLOAD)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cmd       (ctl_cmd),
		.sts       (dp_sts)
	);

endmodule

@@ hw/rtl/bsrs_ctrl.sv @@
// ----------------------------------------------------------------------------
// bsrs_ctrl
// Sequencer for the sender: takes one beat, runs it, then may launch a batch
// or walk the pending bitmap one position per cycle while the slot is free.
// ----------------------------------------------------------------------------
module bsrs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bsrs_pkg::dp_sts_t sts,
	output bsrs_pkg::ctl_cmd_t cmd
);
	import bsrs_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.slot_free) begin
					if (sts.exec_launch) begin
						state_nxt = ST_LAUNCH;
					end else if (sts.exec_scan) begin
						state_nxt = ST_SCAN;
					end else begin
						state_nxt = ST_IDLE;
					end
				end
			end
			ST_LAUNCH: begin
				if (sts.slot_free) begin
					state_nxt = sts.launch_scan ? ST_SCAN : ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (sts.slot_free && sts.scan_done) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		cmd.latch  = (state_q == ST_IDLE) && in_valid;
		cmd.exec   = (state_q == ST_EXEC) && sts.slot_free;
		cmd.launch = (state_q == ST_LAUNCH) && sts.slot_free;
		cmd.scan   = (state_q == ST_SCAN) && sts.slot_free;
	end

endmodule

@@ hw/rtl/bsrs_dp.sv @@
// ----------------------------------------------------------------------------
// bsrs_dp
// Datapath of the sender: configuration registers, transfer state, pending
// bitmap, result composition and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsrs_dp #(
	parameter int MAX_WINDOW   = bsrs_pkg::MAX_WINDOW_DEF,
	parameter int FULL_PAYLOAD = bsrs_pkg::FULL_PAYLOAD_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_wdata,
	input  bsrs_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output bsrs_pkg::out_item_t out_data,
	input  bsrs_pkg::ctl_cmd_t  cmd,
	output bsrs_pkg::dp_sts_t   sts
);
	import bsrs_pkg::*;

	localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam logic [10:0]      FULL_LEN = 11'(FULL_PAYLOAD);
	localparam logic [CNT_W-1:0] WMAX     = CNT_W'(MAX_WINDOW);

	logic [CNT_W-1:0]      window_q;
	logic [15:0]           timeout_q;
	in_item_t              in_q;
	phase_t                phase_q;
	logic [MAX_WINDOW-1:0] pend_q;
	logic [15:0]           base_q;
	logic [CNT_W-1:0]      count_q;
	logic [15:0]           total_q;
	logic [10:0]           flen_q;
	logic [30:0]           sess_q;
	logic [15:0]           tick_q;
	logic [IW-1:0]         idx_q;
	out_item_t             out_q;
	logic                  out_valid_q;

	logic                  match;
	logic                  begin_ok;
	logic                  refuse;
	logic                  open_ok;
	logic                  end_ok;
	logic                  ack_hit;
	logic [31:0]           ack_off;
	logic                  tick_inc;
	logic                  fire;
	logic                  next_batch;
	logic                  resend;
	logic                  have_data;
	logic [CNT_W-1:0]      w_clamp;
	logic [15:0]           remaining;
	logic [CNT_W-1:0]      w_batch;
	logic [MAX_WINDOW-1:0] w_mask;
	logic [MAX_WINDOW-1:0] cnt_mask;
	logic [MAX_WINDOW-1:0] above_mask;
	logic                  cur_pend;
	logic                  more_pend;
	logic [15:0]           data_seq;
	logic [10:0]           data_len;
	logic                  slot_free;
	logic                  emit;
	out_item_t             emit_item;

	always_comb begin
		match     = (in_q.rx_type == RX_ACK) && (in_q.rx_seq == {1'b0, sess_q});
		begin_ok  = (in_q.cmd == CMD_BEGIN) && (phase_q == PH_IDLE);
		refuse    = (in_q.cmd == CMD_RX) && (phase_q == PH_WSTART) && !match;
		open_ok   = (in_q.cmd == CMD_RX) && (phase_q == PH_WSTART) && match;
		end_ok    = (in_q.cmd == CMD_RX) && (phase_q == PH_WEND) && match;
		ack_off   = in_q.rx_seq - {16'd0, base_q};
		ack_hit   = (in_q.cmd == CMD_RX) && (phase_q == PH_DATA) && (in_q.rx_type == RX_ACK)
			&& (in_q.rx_seq >= {16'd0, base_q}) && (ack_off < {25'd0, count_q});
		tick_inc  = (in_q.cmd == CMD_TICK) && (phase_q == PH_DATA) && (tick_q < timeout_q);
		fire      = (in_q.cmd == CMD_TICK) && (phase_q == PH_DATA) && !(tick_q < timeout_q);
		next_batch = fire && (pend_q == '0);
		resend    = fire && (pend_q != '0);

		have_data = (base_q < total_q);
		if (window_q == '0) begin
			w_clamp = CNT_W'(1);
		end else if (window_q > WMAX) begin
			w_clamp = WMAX;
		end else begin
			w_clamp = window_q;
		end
		remaining = total_q - base_q;
		w_batch   = ({9'd0, w_clamp} > remaining) ? remaining[CNT_W-1:0] : w_clamp;

		for (int j = 0; j < MAX_WINDOW; j++) begin
			w_mask[j]     = (j < int'(w_batch));
			cnt_mask[j]   = (j < int'(count_q));
			above_mask[j] = (j > int'(idx_q));
		end
		cur_pend  = pend_q[idx_q];
		more_pend = |(pend_q & above_mask);
		data_seq  = base_q + {{(16-IW){1'b0}}, idx_q};
		data_len  = (({1'b0, data_seq} + 17'd1) == {1'b0, total_q}) ? flen_q : FULL_LEN;
	end

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		sts.slot_free   = slot_free;
		sts.exec_launch = open_ok || next_batch;
		sts.exec_scan   = resend;
		sts.launch_scan = have_data;
		sts.scan_done   = cur_pend && !more_pend;
	end

	always_comb begin
		emit      = 1'b0;
		emit_item = '0;
		if (cmd.exec) begin
			if (begin_ok) begin
				emit                 = 1'b1;
				emit_item.event_res  = EV_SEND;
				emit_item.pkt_type   = PKT_START;
				emit_item.pkt_seq    = {1'b0, in_q.start_seq};
				emit_item.last       = 1'b1;
			end else if (refuse) begin
				emit                 = 1'b1;
				emit_item.event_res  = EV_REFUSED;
				emit_item.last       = 1'b1;
			end else if (end_ok) begin
				emit                 = 1'b1;
				emit_item.event_res  = EV_DONE;
				emit_item.last       = 1'b1;
			end
		end else if (cmd.launch && !have_data) begin
			emit                 = 1'b1;
			emit_item.event_res  = EV_SEND;
			emit_item.pkt_type   = PKT_END;
			emit_item.pkt_seq    = {1'b0, sess_q};
			emit_item.last       = 1'b1;
		end else if (cmd.scan && cur_pend) begin
			emit                 = 1'b1;
			emit_item.event_res  = EV_SEND;
			emit_item.pkt_type   = PKT_DATA;
			emit_item.pkt_seq    = {16'd0, data_seq};
			emit_item.pkt_length = data_len;
			emit_item.last       = !more_pend;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= WINDOW_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WINDOW:  window_q  <= cfg_wdata[CNT_W-1:0];
				CFG_TIMEOUT: timeout_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			in_q <= in_data;
		end
		if (emit) begin
			out_q <= emit_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pend_q  <= '0;
			base_q  <= '0;
			count_q <= '0;
			total_q <= '0;
			flen_q  <= '0;
			sess_q  <= '0;
			tick_q  <= '0;
			idx_q   <= '0;
		end else if (cmd.exec) begin
			if (begin_ok) begin
				total_q <= in_q.packet_count;
				flen_q  <= (in_q.last_length > FULL_LEN) ? FULL_LEN : in_q.last_length;
				sess_q  <= in_q.start_seq;
				pend_q  <= '0;
				base_q  <= '0;
				count_q <= '0;
				tick_q  <= '0;
				phase_q <= PH_WSTART;
			end else if (refuse || end_ok) begin
				phase_q <= PH_IDLE;
			end else if (open_ok) begin
				base_q <= '0;
			end else if (ack_hit) begin
				pend_q[ack_off[IW-1:0]] <= 1'b0;
			end else if (tick_inc) begin
				tick_q <= tick_q + 16'd1;
			end else if (fire) begin
				tick_q <= '0;
				idx_q  <= '0;
				if (next_batch) begin
					base_q <= base_q + {9'd0, count_q};
				end
			end
		end else if (cmd.launch) begin
			if (have_data) begin
				count_q <= w_batch;
				pend_q  <= w_mask;
				tick_q  <= '0;
				idx_q   <= '0;
				phase_q <= PH_DATA;
			end else begin
				count_q <= '0;
				pend_q  <= '0;
				phase_q <= PH_WEND;
			end
		end else if (cmd.scan) begin
			idx_q <= idx_q + IW'(1);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`CHK_IMPLY(a_emit_slot, emit, (!out_valid_q || out_ready), "result written over a waiting beat")
	`CHK_ALWAYS(a_pend_in_batch, ((pend_q & ~cnt_mask) == '0), "pending bit outside the batch")
	`CHK_IMPLY(a_scan_idx, cmd.scan, ({{(CNT_W-IW){1'b0}}, idx_q} < count_q), "scan past batch end")
	`CHK_IMPLY(a_idle_clean, (phase_q == PH_IDLE), (pend_q == '0), "pending bits left while idle")

endmodule

@@ dv/bsrs_event_checker.sv @@
// ----------------------------------------------------------------------------
// bsrs_event_checker
// Watches the command, event and register ports of the batched selective
// repeat sender, keeps its own copy of the transfer state, predicts every
// event beat and compares the beats that leave the block in order.
// ----------------------------------------------------------------------------
module bsrs_event_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_wdata,
	input  logic                in_valid,
	input  logic                in_ready,
	input  bsrs_pkg::in_item_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  bsrs_pkg::out_item_t out_data,
	output int                  fail_count,
	output int                  events_due,
	output bsrs_pkg::phase_t    sender_phase,
	output logic [31:0]         batch_first,
	output logic [63:0]         unacked
);
	timeunit 1ns;
	timeprecision 1ps;

	import bsrs_pkg::*;

	logic [6:0]  window_size;
	logic [15:0] timeout_ticks;
	logic [31:0] batch_len;
	logic [31:0] total_pkts;
	logic [31:0] final_len;
	logic [30:0] session;
	logic [31:0] tick_cnt;

	out_item_t burst[$];
	out_item_t due_events[$];

	function automatic logic [10:0] data_len(input logic [31:0] seq);
		if (seq + 32'd1 == total_pkts)
			return (final_len > FULL_PAYLOAD_DEF) ? 11'(FULL_PAYLOAD_DEF) : final_len[10:0];
		return 11'(FULL_PAYLOAD_DEF);
	endfunction

	task automatic emit(input logic [1:0] ev, input logic [1:0] ty, input logic [31:0] seq,
			input logic [10:0] len);
		out_item_t r;
		r.event_res  = ev;
		r.pkt_type   = ty;
		r.pkt_seq    = seq;
		r.pkt_length = len;
		r.last       = 1'b0;
		burst.push_back(r);
	endtask

	task automatic launch_batch();
		logic [31:0] w;
		int i;
		w = 32'(window_size);
		if (w == 0)
			w = 1;
		if (w > MAX_WINDOW_DEF)
			w = MAX_WINDOW_DEF;
		if (batch_first >= total_pkts) begin
			batch_len = 0;
			unacked = '0;
			emit(EV_SEND, PKT_END, {1'b0, session}, '0);
			sender_phase = PH_WEND;
		end else begin
			if (w > total_pkts - batch_first)
				w = total_pkts - batch_first;
			batch_len = w;
			unacked = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
			for (i = 0; i < w; i++)
				emit(EV_SEND, PKT_DATA, batch_first + 32'(i), data_len(batch_first + 32'(i)));
			tick_cnt = 0;
			sender_phase = PH_DATA;
		end
	endtask

	task automatic advance_sender(input in_item_t it);
		logic ack_match;
		logic [31:0] off;
		out_item_t r;
		int i;
		burst.delete();
		ack_match = (it.rx_type == RX_ACK) && (it.rx_seq == {1'b0, session});
		case (it.cmd)
			CMD_BEGIN: begin
				if (sender_phase == PH_IDLE) begin
					total_pkts = 32'(it.packet_count);
					final_len = 32'(it.last_length);
					session = it.start_seq;
					unacked = '0;
					batch_first = 0;
					batch_len = 0;
					tick_cnt = 0;
					emit(EV_SEND, PKT_START, {1'b0, it.start_seq}, '0);
					sender_phase = PH_WSTART;
				end
			end
			CMD_RX: begin
				if (sender_phase == PH_WSTART) begin
					if (ack_match) begin
						batch_first = 0;
						launch_batch();
					end else begin
						emit(EV_REFUSED, '0, '0, '0);
						sender_phase = PH_IDLE;
					end
				end else if (sender_phase == PH_DATA) begin
					off = it.rx_seq - batch_first;
					if (it.rx_type == RX_ACK && it.rx_seq >= batch_first && off < batch_len)
						unacked[off[5:0]] = 1'b0;
				end else if (sender_phase == PH_WEND && ack_match) begin
					emit(EV_DONE, '0, '0, '0);
					sender_phase = PH_IDLE;
				end
			end
			CMD_TICK: begin
				if (sender_phase == PH_DATA) begin
					if (tick_cnt < 32'(timeout_ticks)) begin
						tick_cnt++;
					end else begin
						tick_cnt = 0;
						if (unacked == '0) begin
							batch_first += batch_len;
							launch_batch();
						end else begin
							for (i = 0; i < batch_len; i++)
								if (unacked[i])
									emit(EV_SEND, PKT_DATA, batch_first + 32'(i),
										data_len(batch_first + 32'(i)));
						end
					end
				end
			end
			default: ;
		endcase
		if (burst.size() > 0) begin
			r = burst.pop_back();
			r.last = 1'b1;
			burst.push_back(r);
		end
		while (burst.size() > 0)
			due_events.push_back(burst.pop_front());
	endtask

	task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s expected %0d actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_beat(input out_item_t got);
		out_item_t want;
		if (due_events.size() == 0) begin
			$error("beat with no event due: event_res %0d pkt_type %0d pkt_seq %0d",
				got.event_res, got.pkt_type, got.pkt_seq);
			fail_count++;
		end else begin
			want = due_events.pop_front();
			cmp_field("event_res", 32'(want.event_res), 32'(got.event_res));
			cmp_field("pkt_type", 32'(want.pkt_type), 32'(got.pkt_type));
			cmp_field("pkt_seq", want.pkt_seq, got.pkt_seq);
			cmp_field("pkt_length", 32'(want.pkt_length), 32'(got.pkt_length));
			cmp_field("last", 32'(want.last), 32'(got.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size = WINDOW_RST;
			timeout_ticks = TIMEOUT_RST;
			sender_phase = PH_IDLE;
			unacked = '0;
			batch_first = 0;
			batch_len = 0;
			total_pkts = 0;
			final_len = 0;
			session = '0;
			tick_cnt = 0;
			fail_count = 0;
			due_events.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_WINDOW)
					window_size = cfg_wdata[6:0];
				else
					timeout_ticks = cfg_wdata;
			end
			if (in_valid && in_ready)
				advance_sender(in_data);
			if (out_valid && out_ready)
				check_beat(out_data);
		end
		events_due = due_events.size();
	end

endmodule

@@ dv/tb_batched_selective_repeat_sender.sv @@
// ----------------------------------------------------------------------------
// tb_batched_selective_repeat_sender
// Drives transfers through the batched selective repeat sender: a directed
// walk through the corner cases, then random transfers with lost and stray
// acknowledgements, timer ticks and refusals under changing window and
// timeout settings and varying back-pressure. The checker beside the block
// predicts and compares every event beat.
// ----------------------------------------------------------------------------
module tb_batched_selective_repeat_sender;
	timeunit 1ns;
	timeprecision 1ps;

	import bsrs_pkg::*;

	localparam logic [1:0] CMD_SPARE      = 2'd3;
	localparam logic [1:0] RX_DATA_PKT    = 2'd2;
	localparam int         LATENCY_CYCLES = 8;
	localparam int         HOLD_CYCLES    = 400;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;

	int          fail_count;
	int          events_due;
	phase_t      sender_phase;
	logic [31:0] batch_first;
	logic [63:0] unacked;

	int tx_idle_pct = 17;
	int rx_idle_pct = 50;
	int rx_hold_left = 0;
	int n_items = 0;

	batched_selective_repeat_sender u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	bsrs_event_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data),
		.fail_count   (fail_count),
		.events_due   (events_due),
		.sender_phase (sender_phase),
		.batch_first  (batch_first),
		.unacked      (unacked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("[batched_selective_repeat_sender] ERROR");
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				out_ready <= 1'b0;
				rx_hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	function automatic in_item_t rand_item();
		in_item_t it;
		it.cmd = CMD_SPARE;
		it.packet_count = 16'($urandom);
		it.last_length = 11'($urandom);
		it.start_seq = 31'($urandom);
		it.rx_type = 2'($urandom);
		it.rx_seq = $urandom;
		return it;
	endfunction

	function automatic in_item_t begin_cmd(input logic [15:0] count, input logic [10:0] len,
			input logic [30:0] seq);
		in_item_t it;
		it = rand_item();
		it.cmd = CMD_BEGIN;
		it.packet_count = count;
		it.last_length = len;
		it.start_seq = seq;
		return it;
	endfunction

	function automatic in_item_t rx_cmd(input logic [1:0] rtype, input logic [31:0] seq);
		in_item_t it;
		it = rand_item();
		it.cmd = CMD_RX;
		it.rx_type = rtype;
		it.rx_seq = seq;
		return it;
	endfunction

	function automatic in_item_t tick_cmd();
		in_item_t it;
		it = rand_item();
		it.cmd = CMD_TICK;
		return it;
	endfunction

	// Commands that the sender drops in the data and end phases.
	function automatic in_item_t stray_item();
		in_item_t it;
		it = rand_item();
		case ($urandom_range(3))
			0: it.cmd = CMD_BEGIN;
			1: it.cmd = CMD_SPARE;
			2: begin
				it.cmd = CMD_RX;
				it.rx_type = 2'($urandom_range(2));
			end
			default: begin
				it.cmd = CMD_RX;
				it.rx_type = RX_ACK;
				it.rx_seq[31] = 1'b1;
			end
		endcase
		return it;
	endfunction

	task automatic offer(input in_item_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (events_due != 0)
			@(negedge clk);
		repeat (LATENCY_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input int value);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= 16'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drive_transfer(input int count, input bit refuse);
		logic [30:0] seq;
		int pick;
		int off;
		int guard;
		seq = 31'($urandom);
		offer(begin_cmd(16'(count), 11'($urandom_range(2047)), seq));
		n_items++;
		if (refuse) begin
			if ($urandom_range(1) == 1)
				offer(rx_cmd(2'($urandom_range(2)), {1'b0, seq}));
			else
				offer(rx_cmd(RX_ACK, {1'b1, 31'($urandom)}));
			n_items++;
			return;
		end
		offer(rx_cmd(RX_ACK, {1'b0, seq}));
		n_items++;
		guard = 0;
		while (sender_phase != PH_IDLE && guard < 5000) begin
			guard++;
			pick = $urandom_range(99);
			if (sender_phase == PH_DATA) begin
				if (pick < 55 && unacked != '0) begin
					off = $urandom_range(63);
					while (!unacked[off])
						off = (off + 1) % 64;
					offer(rx_cmd(RX_ACK, batch_first + 32'(off)));
					n_items++;
				end else if (pick < 88) begin
					offer(tick_cmd());
					n_items++;
				end else begin
					offer(stray_item());
				end
			end else begin
				if (pick < 70) begin
					offer(rx_cmd(RX_ACK, {1'b0, seq}));
					n_items++;
				end else if (pick < 80) begin
					offer(tick_cmd());
				end else begin
					offer(stray_item());
				end
			end
		end
	endtask

	task automatic random_transfers(input int target, input bit reconfig);
		int stop;
		int r;
		stop = n_items + target;
		while (n_items < stop) begin
			if (reconfig) begin
				write_reg(CFG_WINDOW, $urandom_range(127));
				write_reg(CFG_TIMEOUT, $urandom_range(4));
			end
			r = $urandom_range(7);
			if (r == 0)
				drive_transfer($urandom_range(65535), 1'b1);
			else if (r == 1)
				drive_transfer(0, 1'b0);
			else
				drive_transfer($urandom_range(12, 1), 1'b0);
		end
	endtask

	initial begin
		logic [30:0] seq;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_WINDOW;
		cfg_wdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_reg(CFG_WINDOW, 3);
		write_reg(CFG_TIMEOUT, 0);
		offer(rx_cmd(RX_ACK, 32'd0));
		offer(tick_cmd());
		offer(stray_item());
		offer(begin_cmd(16'd0, 11'd0, 31'h7FFF_FFFF));
		offer(begin_cmd(16'd9, 11'd5, 31'd1));
		offer(rx_cmd(RX_ACK, 32'h7FFF_FFFF));
		offer(tick_cmd());
		offer(rx_cmd(RX_ACK, 32'hFFFF_FFFF));
		offer(rx_cmd(RX_DATA_PKT, 32'h7FFF_FFFF));
		offer(rx_cmd(RX_ACK, 32'h7FFF_FFFF));
		offer(begin_cmd(16'd5, 11'h7FF, 31'd0));
		offer(rx_cmd(RX_DATA_PKT, 32'd0));
		offer(begin_cmd(16'd5, 11'd0, 31'h1234_5678));
		offer(rx_cmd(RX_ACK, 32'h1234_5678));
		offer(rx_cmd(RX_ACK, 32'd1));
		offer(rx_cmd(RX_ACK, 32'd5));
		offer(tick_cmd());
		offer(rx_cmd(RX_ACK, 32'd0));
		offer(rx_cmd(RX_ACK, 32'd2));
		offer(tick_cmd());
		offer(rx_cmd(RX_ACK, 32'hFFFF_FFFF));
		offer(rx_cmd(RX_ACK, 32'd3));
		offer(rx_cmd(RX_ACK, 32'd4));
		offer(tick_cmd());
		offer(rx_cmd(RX_ACK, 32'h1234_5678));

		write_reg(CFG_WINDOW, 0);
		write_reg(CFG_TIMEOUT, 1);
		random_transfers(30, 1'b0);

		settle();
		tx_idle_pct = 50;
		rx_idle_pct = 17;
		write_reg(CFG_WINDOW, 64);
		write_reg(CFG_TIMEOUT, 3);
		// A long receiver stall under a full window fills the block.
		rx_hold_left = HOLD_CYCLES;
		drive_transfer(70, 1'b0);
		random_transfers(20, 1'b0);

		settle();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		random_transfers(30, 1'b1);

		write_reg(CFG_WINDOW, 5);
		write_reg(CFG_TIMEOUT, 65535);
		drive_transfer(0, 1'b0);
		drive_transfer($urandom_range(65535), 1'b1);
		seq = 31'($urandom);
		offer(begin_cmd(16'd2, 11'd1456, seq));
		offer(rx_cmd(RX_ACK, {1'b0, seq}));
		repeat (6) offer(tick_cmd());
		offer(rx_cmd(RX_ACK, batch_first));

		settle();
		if (fail_count == 0)
			$display("[batched_selective_repeat_sender] OK");
		else
			$display("[batched_selective_repeat_sender] ERROR");
		$finish;
	end

endmodule
